### rtl/nearest_palette_color_unit_assert.svh
// Assertion macros for the nearest palette color unit.
`ifndef NEAREST_PALETTE_COLOR_UNIT_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// cond must never hold outside reset
`define NPC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("npc: forbidden condition seen");

// ante implies cons in the same cycle
`define NPC_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("npc: implication violated");

`else

`define NPC_ASSERT_NEVER(lbl, cond)
`define NPC_ASSERT_IMPLIES(lbl, ante, cons)

`endif

`endif

### rtl/npc_pkg.sv
// Package: types and constants of the nearest palette color unit.
`timescale 1ns / 1ps
`default_nettype none

package npc_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LIM_W       = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W       = 8;
  localparam int CHAN_W      = 8;
  localparam int CNT_W       = 9;
  localparam int SQ_W        = 2 * CHAN_W;
  localparam int DIST_W      = SQ_W + 2;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    opcode_t          opcode;
    logic [IDX_W-1:0] entry_index;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] match_index;
  } out_item_t;

endpackage

`default_nettype wire

### rtl/nearest_palette_color_unit.sv
// Top level: palette store and sequential nearest-color search.
`timescale 1ns / 1ps
`default_nettype none
//
// Channel  Ports                         Direction  Moves
// -------  ----------------------------  ---------  ------------------------------
// in       in_valid/in_ready/in_data      input      write or query transaction
// out      out_valid/out_ready/out_data   output     found flag and match index
// cfg      cfg_we/cfg_wdata               input      entry_count register write
//
// A write transaction is done at its acceptance edge; in_ready stays high.
// A query with N = min(entry_count, TABLE_DEPTH) > 0 holds in_ready low while it makes
// N reads, drains the square and compare stages, sees the scan end and loads the result
// register. With N = 0 no entries are read.
// Reset (rst_n low, synchronous) clears control state and entry_count, not the palette.
// A pending result does not block input; a finished query waits until the previous result is claimed.

module nearest_palette_color_unit
  import npc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata
);

  `include "nearest_palette_color_unit_assert.svh"

  // control
  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r;
  logic [LIM_W-1:0]    lim_r, lim_nxt;
  logic [LIM_W-1:0]    iss_r;
  rgb_t                px_r;

  // search pipeline: memory read -> squares -> accumulate/compare
  logic                v1_r, v2_r;
  logic [ADDR_W-1:0]   idx1_r, idx2_r;
  rgb_t                rd_word_r;
  logic [SQ_W-1:0]     sq_r [3];
  logic                have_r;
  logic [DIST_W-1:0]   best_d_r;
  logic [ADDR_W-1:0]   best_i_r;

  logic                out_valid_r;
  out_item_t           out_data_r;

  rgb_t                palette_mem [TABLE_DEPTH];

  logic                in_fire, out_fire;
  logic                issue, scan_done, load_out;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr, rd_addr;
  rgb_t                wr_word;
  logic [CHAN_W-1:0]   diff [3];
  logic [DIST_W-1:0]   dist_sum;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // effective entry count, saturated at the table depth
  always_comb begin
    if (32'(count_r) > TABLE_DEPTH) begin
      lim_nxt = LIM_W'(TABLE_DEPTH);
    end else begin
      lim_nxt = LIM_W'(count_r);
    end
  end

  assign scan_done = (iss_r == lim_r) && !v1_r && !v2_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_data.opcode == OP_QUERY) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    load_out = 1'b0;
    case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_SCAN:   issue    = (iss_r != lim_r);
      ST_FINISH: load_out = !out_valid_r || out_ready;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_we) begin
      count_r <= cfg_wdata;
    end
  end

  // palette memory: one write port, one registered read port
  assign wr_en   = in_fire && in_data.opcode == OP_WRITE &&
                   32'(in_data.entry_index) < TABLE_DEPTH;
  assign wr_addr = ADDR_W'(in_data.entry_index);
  assign wr_word = '{red: in_data.red, green: in_data.green, blue: in_data.blue};
  assign rd_addr = iss_r[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) palette_mem[wr_addr] <= wr_word;
    if (issue) rd_word_r <= palette_mem[rd_addr];
  end

  // query latch and read sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r <= '0;
      lim_r <= '0;
    end else if (in_fire && in_data.opcode == OP_QUERY) begin
      iss_r <= '0;
      lim_r <= lim_nxt;
    end else if (issue) begin
      iss_r <= iss_r + LIM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_data.opcode == OP_QUERY) begin
      px_r <= '{red: in_data.red, green: in_data.green, blue: in_data.blue};
    end
  end

  // distance unit, stage 1: channel differences squared
  always_comb begin
    diff[0] = (rd_word_r.red > px_r.red) ? rd_word_r.red - px_r.red
                                         : px_r.red - rd_word_r.red;
    diff[1] = (rd_word_r.green > px_r.green) ? rd_word_r.green - px_r.green
                                             : px_r.green - rd_word_r.green;
    diff[2] = (rd_word_r.blue > px_r.blue) ? rd_word_r.blue - px_r.blue
                                           : px_r.blue - rd_word_r.blue;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      sq_r[k] <= SQ_W'(diff[k]) * SQ_W'(diff[k]);
    end
    idx1_r <= rd_addr;
    idx2_r <= idx1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
    end
  end

  // distance unit, stage 2: sum and keep the running minimum
  assign dist_sum = DIST_W'(sq_r[0]) + DIST_W'(sq_r[1]) + DIST_W'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (in_fire && in_data.opcode == OP_QUERY) begin
      have_r <= 1'b0;
    end else if (v2_r) begin
      have_r <= 1'b1;
    end
  end

  // strict less-than keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (v2_r && (!have_r || dist_sum < best_d_r)) begin
      best_d_r <= dist_sum;
      best_i_r <= idx2_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.found       <= have_r;
      out_data_r.match_index <= have_r ? IDX_W'(best_i_r) : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // pipeline only carries entries while a query is scanning
  `NPC_ASSERT_NEVER(a_pipe_idle, (v1_r || v2_r) && state_r != ST_SCAN)
  // the read sequencer never runs past the saturated count
  `NPC_ASSERT_NEVER(a_iss_bound, iss_r > lim_r)
  // an empty search reports index zero
  `NPC_ASSERT_IMPLIES(a_empty_idx, out_valid && !out_data.found,
                      out_data.match_index == '0)

endmodule

`default_nettype wire

### test/tb.sv
// Self-checking testbench for the nearest palette color unit.
`timescale 1ns / 1ps
`default_nettype none

module tb;
  import npc_pkg::*;

  // Watchdog: the slowest legal gap between transactions is a full-table scan
  // plus the longest send gap and the longest receiver stall,
  // plus the short pause before a register write. Several times that.
  localparam int WATCHDOG_LIMIT = 3000;
  // After the last result, allow one more full scan before declaring quiet.
  localparam int DRAIN_CYCLES   = TABLE_DEPTH + 8;
  // This pause lets a trailing write land before touching entry_count.
  localparam int CFG_PAUSE      = 8;
  localparam int TARGET_ITEMS   = 1800;
  localparam int MAX_REPORTS    = 10;
  localparam int COUNT_MAX      = (1 << CNT_W) - 1;
  // Phase in which the one-time fill of all unwritten entries happens.
  localparam int FILL_PHASE     = 5;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_we    = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  nearest_palette_color_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the block: palette contents and entry_count as the DUT
  // should hold them, updated at the edge where each transaction is accepted.
  // ---------------------------------------------------------------------------
  rgb_t             shadow_palette [TABLE_DEPTH];
  logic [CNT_W-1:0] shadow_count = '0;

  // Expected query results, oldest first.
  out_item_t match_q [$];
  // Write/query transactions waiting to be driven.
  in_item_t  palette_req_q [$];

  // Generator-side view of which slots hold data (guards against scanning
  // entries that were never written since reset).
  rgb_t gen_palette [TABLE_DEPTH];
  bit   gen_written [TABLE_DEPTH];

  int req_issued   = 0;
  int req_accepted = 0;
  int res_accepted = 0;
  int err_cnt      = 0;
  int n_writes     = 0;
  int n_queries    = 0;
  int n_found      = 0;
  int n_cfg        = 0;
  int n_sent       = 0;
  int idle_cycles  = 0;

  // Per-phase switches: random gaps on the sender / random stalls on the receiver.
  bit send_idle = 1'b0;
  bit recv_idle = 1'b0;
  int send_gap  = 0;
  int hold_gap  = 0;
  int res_seen  = 0;

  rgb_t common_colors [6] = '{24'h000000, 24'hFFFFFF, 24'h808080,
                              24'hFF0000, 24'h00FF00, 24'h0000FF};

  // Squared RGB distance, exact, DIST_W bits wide.
  function automatic logic [DIST_W-1:0] color_dist(rgb_t a, rgb_t b);
    logic [DIST_W-1:0] dr, dg, db;
    dr = (a.red   > b.red)   ? DIST_W'(a.red - b.red)     : DIST_W'(b.red - a.red);
    dg = (a.green > b.green) ? DIST_W'(a.green - b.green) : DIST_W'(b.green - a.green);
    db = (a.blue  > b.blue)  ? DIST_W'(a.blue - b.blue)   : DIST_W'(b.blue - a.blue);
    return dr * dr + dg * dg + db * db;
  endfunction

  // Nearest entry among the first entry_count slots; strict less-than while
  // scanning up keeps the lowest index on a tie. Count saturates at the table.
  function automatic out_item_t nearest_match(rgb_t px);
    out_item_t         res;
    logic [DIST_W-1:0] best;
    logic [DIST_W-1:0] d;
    int                lim;
    res  = '0;
    best = '0;
    lim  = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
    for (int i = 0; i < lim; i++) begin
      d = color_dist(shadow_palette[i], px);
      if (!res.found || d < best) begin
        res.found       = 1'b1;
        res.match_index = IDX_W'(i);
        best            = d;
      end
    end
    return res;
  endfunction

  // Number of slots from index 0 up that have all been written.
  function automatic int written_prefix();
    int n;
    n = 0;
    while (n < TABLE_DEPTH && gen_written[n]) n++;
    return n;
  endfunction

  function automatic rgb_t pick_color();
    if ($urandom_range(0, 9) < 3) return common_colors[$urandom_range(0, 5)];
    return rgb_t'($urandom());
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: samples at the rising edge. Accepted writes update the shadow
  // palette, accepted queries queue their expected result, and each accepted
  // result is checked against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : p_check
    rgb_t      px;
    out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        px.red   = in_data.red;
        px.green = in_data.green;
        px.blue  = in_data.blue;
        if (in_data.opcode == OP_WRITE) begin
          shadow_palette[in_data.entry_index] = px;
          n_writes++;
        end else begin
          match_q.push_back(nearest_match(px));
          n_queries++;
        end
        req_accepted++;
      end
      if (out_valid && out_ready) begin
        res_accepted++;
        if (match_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: result with no query pending: found=%0b index=%0d",
                     $realtime, out_data.found, out_data.match_index);
        end else begin
          want = match_q.pop_front();
          if (out_data.found !== want.found || out_data.match_index !== want.match_index) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
              $display("%0t: result %0d: expected found=%0b index=%0d, got found=%0b index=%0d",
                       $realtime, res_accepted, want.found, want.match_index,
                       out_data.found, out_data.match_index);
          end else if (want.found) begin
            n_found++;
          end
        end
      end
    end
  end

  // Watchdog: any accepted transaction or register write restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: falling edge. Holds valid and payload until acceptance, then waits
  // the gap drawn for that transaction before presenting the next one. Only
  // one assignment to in_valid per edge, so back-to-back keeps valid high.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && req_issued != req_accepted)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (palette_req_q.size() != 0) begin
        in_data  <= palette_req_q.pop_front();
        in_valid <= 1'b1;
        req_issued++;
        send_gap = send_idle ? $urandom_range(0, 10) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: a fresh stall is drawn after every accepted result.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (res_seen != res_accepted) begin
        res_seen = res_accepted;
        hold_gap = recv_idle ? $urandom_range(0, 10) : 0;
      end
      if (hold_gap > 0) begin
        hold_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_write(int idx, rgb_t col);
    in_item_t it;
    it.opcode      = OP_WRITE;
    it.entry_index = IDX_W'(idx);
    it.red         = col.red;
    it.green       = col.green;
    it.blue        = col.blue;
    palette_req_q.push_back(it);
    gen_palette[idx] = col;
    gen_written[idx] = 1'b1;
    n_sent++;
  endtask

  // entry_index is don't-care on a query; fill it randomly anyway.
  task automatic push_query(rgb_t col);
    in_item_t it;
    it.opcode      = OP_QUERY;
    it.entry_index = IDX_W'($urandom_range(0, 255));
    it.red         = col.red;
    it.green       = col.green;
    it.blue        = col.blue;
    palette_req_q.push_back(it);
    n_sent++;
  endtask

  // Block until every queued transaction is accepted and every result is in,
  // then give a trailing write time to land.
  task automatic wait_quiet();
    do @(negedge clk);
    while (palette_req_q.size() != 0 || req_issued != req_accepted || match_q.size() != 0);
    repeat (CFG_PAUSE) @(negedge clk);
  endtask

  task automatic set_palette_count(int cnt);
    wait_quiet();
    cfg_we       <= 1'b1;
    cfg_wdata    <= CNT_W'(cnt);
    shadow_count = CNT_W'(cnt);
    n_cfg++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One random transaction for a phase running with entry_count = cnt.
  task automatic push_random_item(int cnt);
    int   lim;
    int   pre;
    int   idx;
    int   r;
    rgb_t col;
    lim = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;
    if ($urandom_range(0, 99) < 45) begin
      // Bias some writes just past the written prefix so the palette grows.
      pre = written_prefix();
      if (pre < TABLE_DEPTH && $urandom_range(0, 2) == 0) begin
        idx = pre + $urandom_range(0, 3);
        if (idx > TABLE_DEPTH - 1) idx = TABLE_DEPTH - 1;
      end else begin
        idx = $urandom_range(0, TABLE_DEPTH - 1);
      end
      push_write(idx, pick_color());
    end else begin
      r = $urandom_range(0, 9);
      if (lim > 0 && r < 3) col = gen_palette[$urandom_range(0, lim - 1)];  // exact hit
      else if (r < 5)       col = common_colors[$urandom_range(0, 5)];
      else                  col = rgb_t'($urandom());
      push_query(col);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : p_stimulus
    int cnt;
    int pre;
    int r;
    int phase;
    int forced_i;
    int forced_cnt [4];

    forced_cnt = '{TABLE_DEPTH, COUNT_MAX, TABLE_DEPTH + 1, TABLE_DEPTH - 1};
    forced_i   = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty palette: every query reports not found.
    set_palette_count(0);
    push_query(24'h000000);
    push_query(24'hFFFFFF);

    // Small palette with a duplicate color at slots 0 and 2, plus the top slot.
    push_write(0, 24'h000000);
    push_write(1, 24'hFFFFFF);
    push_write(2, 24'h000000);
    push_write(3, 24'h808080);
    push_write(TABLE_DEPTH - 1, 24'hFF00FF);

    // Single entry in use: always index 0.
    set_palette_count(1);
    push_query(24'hFFFFFF);

    set_palette_count(4);
    push_query(24'h000000);   // exact tie between 0 and 2
    push_query(24'hFFFFFF);
    push_query(24'h404040);   // equidistant from black and mid-gray
    push_query(24'h827E81);
    push_query(24'hFF0000);
    push_query(24'h00FF7F);

    // Random phases: each sets entry_count within the written prefix, picks its idle
    // pattern, then queues a burst of writes and queries (only writes in the fill phase).
    phase = 0;
    while (n_sent < TARGET_ITEMS) begin
      pre = written_prefix();
      if (pre == TABLE_DEPTH && forced_i < 4) begin
        cnt = forced_cnt[forced_i];
        forced_i++;
      end else if (pre == TABLE_DEPTH && $urandom_range(0, 7) == 0) begin
        cnt = $urandom_range(TABLE_DEPTH, COUNT_MAX);
      end else begin
        r = $urandom_range(0, 9);
        if (r == 0 || pre == 0)  cnt = 0;
        else if (r == 1)         cnt = (pre <= 64) ? pre : $urandom_range(1, 64);
        else                     cnt = $urandom_range(1, (pre < 48) ? pre : 48);
      end
      set_palette_count(cnt);
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);

      if (phase == FILL_PHASE) begin
        // Populate every slot still empty so full-table counts become legal.
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (!gen_written[i]) push_write(i, pick_color());
      end else begin
        repeat ($urandom_range(20, 80)) push_random_item(cnt);
      end
      phase++;
    end

    wait_quiet();
    repeat (DRAIN_CYCLES) @(negedge clk);
    err_cnt += match_q.size();

    $display("run covered %0d palette writes and %0d queries (%0d nearest hits)",
             n_writes, n_queries, n_found);
    $display("across %0d entry_count settings; %0d bad results", n_cfg, err_cnt);
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

### nearest_palette_color_unit.f
+incdir+rtl
rtl/npc_pkg.sv
rtl/nearest_palette_color_unit.sv
test/tb.sv
